>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_NOW(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_NOW(label, clock, reset, ante, cons)
`define ASSERT_NEXT(label, clock, reset, ante, cons)

`endif

`endif

>>> rtl/b64d_pkg.sv
package b64d_pkg;

  // Character codes of the Base64 alphabet.
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_PAD     = 8'h3D;

  // Sextet values at the start of each character class.
  localparam logic [5:0] SX_LOWER_BASE = 6'd26;
  localparam logic [5:0] SX_DIGIT_BASE = 6'd52;
  localparam logic [5:0] SX_PLUS       = 6'd62;
  localparam logic [5:0] SX_SLASH      = 6'd63;
  localparam logic [5:0] SX_PAD        = 6'd0;

  // Number of sextets held before a group completes.
  localparam logic [1:0] FILL_FULL = 2'd3;
  // Number of bytes produced by one group.
  localparam logic [1:0] BYTES_PER_GROUP = 2'd3;

  typedef struct packed {
    logic       ok;
    logic [5:0] value;
  } sextet_t;

  // Maps one character to its sextet; ok is low for characters outside the alphabet.
  function automatic sextet_t char_to_sextet(input logic [7:0] c);
    sextet_t r;
    r.ok    = 1'b1;
    r.value = SX_PAD;
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      r.value = 6'(c - CH_UPPER_A);
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      r.value = 6'(c - CH_LOWER_A) + SX_LOWER_BASE;
    end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
      r.value = {2'b00, c[3:0]} + SX_DIGIT_BASE;
    end else if (c == CH_PLUS) begin
      r.value = SX_PLUS;
    end else if (c == CH_SLASH) begin
      r.value = SX_SLASH;
    end else if (c == CH_PAD) begin
      r.value = SX_PAD;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

>>> rtl/base64_decoder_resync_top.sv
// Channel    | Handshake               | Payload
// -----------+-------------------------+------------------------------
// character  | char_valid, char_ready  | text_char[7:0], end_of_text
// byte       | byte_valid, byte_ready  | data_byte[7:0], group_last
//
// One character is taken per cycle unless the input register stalls; it is the only stall point.
// An accepted character is decoded from the input register; when it completes a group,
// the group's bytes are registered in the output buffer and offered from there.
// A completed group occupies the three-byte output buffer until its bytes are taken,
// and the buffer can drain while the four characters of the next group come in.
// Reset (rst, synchronous) empties the input register, the group and the buffer.
// A stalled byte channel holds the input register only when it completes a group.
`include "assert_macros.svh"

module base64_decoder_resync_top
  import b64d_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_ready,
  input  logic [7:0] text_char,
  input  logic       end_of_text,
  output logic       byte_valid,
  input  logic       byte_ready,
  output logic [7:0] data_byte,
  output logic       group_last
);

  // Input register.
  logic       held;
  logic [7:0] held_char;
  logic       held_eot;

  // Group under assembly.
  logic [1:0] fill;
  logic [5:0] store [3];

  // Output buffer: bytes leave from slot 0 and shift down.
  logic [1:0] count;
  logic [7:0] obuf [3];

  sextet_t    sx;
  logic       completes;
  logic       buf_free;
  logic       advance;
  logic       pop;
  logic       load;
  logic [1:0] fill_next;
  logic [7:0] byte0_next;
  logic [7:0] byte1_next;
  logic [7:0] byte2_next;

  // Decode of the held character and the flow control around it.
  always_comb begin
    sx         = char_to_sextet(held_char);
    completes  = held && sx.ok && (fill == FILL_FULL);
    pop        = byte_valid && byte_ready;
    buf_free   = (count == 2'd0) || ((count == 2'd1) && byte_ready);
    advance    = held && (!completes || buf_free);
    load       = advance && completes;
    char_ready = !held || advance;
    byte0_next = {store[0], store[1][5:4]};
    byte1_next = {store[1][3:0], store[2][5:2]};
    byte2_next = {store[2][1:0], sx.value};
  end

  // Next fill level of the group.
  always_comb begin
    fill_next = fill;
    if (advance) begin
      if (!sx.ok || completes || held_eot) begin
        fill_next = 2'd0;
      end else begin
        fill_next = fill + 2'd1;
      end
    end
  end

  assign byte_valid = (count != 2'd0);
  assign data_byte  = obuf[0];
  assign group_last = (count == 2'd1);

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      held  <= 1'b0;
      fill  <= 2'd0;
      count <= 2'd0;
    end else begin
      if (char_ready) begin
        held <= char_valid;
      end
      fill <= fill_next;
      if (load) begin
        count <= BYTES_PER_GROUP;
      end else if (pop) begin
        count <= count - 2'd1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (char_ready && char_valid) begin
      held_char <= text_char;
      held_eot  <= end_of_text;
    end
    if (advance && sx.ok && !completes) begin
      store[fill] <= sx.value;
    end
    if (load) begin
      obuf[0] <= byte0_next;
      obuf[1] <= byte1_next;
      obuf[2] <= byte2_next;
    end else if (pop) begin
      obuf[0] <= obuf[1];
      obuf[1] <= obuf[2];
    end
  end

  // A loaded group is offered in full on the next cycle.
  `ASSERT_NEXT(a_load_full, clk, rst, load, count == BYTES_PER_GROUP)
  // Groups are at least four characters apart, so two loads never follow each other.
  `ASSERT_NEXT(a_no_back_load, clk, rst, load, !load)
  // A completed group always leaves the assembly empty.
  `ASSERT_NEXT(a_fill_cleared, clk, rst, load, fill == 2'd0)
  // A held character that cannot move stays in place.
  `ASSERT_NEXT(a_stall_holds, clk, rst, held && !advance, held && $stable(held_char))
  // The input register only stalls on a completed group meeting a busy buffer.
  `ASSERT_NOW(a_stall_cause, clk, rst, held && !advance, completes && count != 2'd0)

endmodule

>>> test/tb_top.sv
module tb_top;
  import b64d_pkg::*;

  // Cycles without any transaction before the run is abandoned.
  localparam int STALL_LIMIT = 2000;
  // Number of random characters to send after the directed table.
  localparam int RANDOM_CHARS = 246;
  // Cycles allowed after the last expected byte before finishing.
  localparam int DRAIN_CYCLES = 12;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_byte_t;

  // One row of the directed table; typed rows carry the bytes they complete.
  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
    logic       typed;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } text_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       char_valid = 1'b0;
  logic       char_ready;
  logic [7:0] text_char = 8'h00;
  logic       end_of_text = 1'b0;
  logic       byte_valid;
  logic       byte_ready = 1'b0;
  logic [7:0] data_byte;
  logic       group_last;

  // Decoder state as the testbench sees it.
  logic [5:0] held_sextets [3];
  logic [1:0] held_count;
  out_byte_t  pending_bytes [$];

  int  errors = 0;
  int  chars_sent = 0;
  int  groups_decoded = 0;
  int  bytes_checked = 0;
  int  stall_cycles = 0;
  bit  no_idle = 1'b0;

  string alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/=";

  text_row_t text_rows [24] = '{
    '{8'h41, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00},
    '{8'h41, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00},
    '{8'h41, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00},
    '{8'h41, 1'b0, 1'b1, 8'h00, 8'h00, 8'h00},
    '{8'h2F, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00},
    '{8'h2F, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00},
    '{8'h2F, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00},
    '{8'h2F, 1'b0, 1'b1, 8'hFF, 8'hFF, 8'hFF},
    '{8'h5A, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00},
    '{8'h7A, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00},
    '{8'hFF, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00},
    '{8'h54, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00},
    '{8'h57, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00},
    '{8'h46, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00},
    '{8'h75, 1'b0, 1'b1, 8'h4D, 8'h61, 8'h6E},
    '{8'h30, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00},
    '{8'h39, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00},
    '{8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00},
    '{8'h2B, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00},
    '{8'h39, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00},
    '{8'h3D, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00},
    '{8'h3D, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00},
    '{8'h40, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00},
    '{8'h5B, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00}
  };

  base64_decoder_resync_top u_dut (
    .clk         (clk),
    .rst         (rst),
    .char_valid  (char_valid),
    .char_ready  (char_ready),
    .text_char   (text_char),
    .end_of_text (end_of_text),
    .byte_valid  (byte_valid),
    .byte_ready  (byte_ready),
    .data_byte   (data_byte),
    .group_last  (group_last)
  );

  // Free-running clock with a period of ten time units.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Maps a character to {valid, sextet}; the valid bit is low outside the alphabet.
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) return {1'b1, 6'(c - CH_UPPER_A)};
    if (c >= CH_LOWER_A && c <= CH_LOWER_Z) return {1'b1, 6'(c - CH_LOWER_A + 8'd26)};
    if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) return {1'b1, 6'(c - CH_DIGIT_0 + 8'd52)};
    if (c == CH_PLUS) return {1'b1, 6'd62};
    if (c == CH_SLASH) return {1'b1, 6'd63};
    if (c == CH_PAD) return {1'b1, 6'd0};
    return 7'd0;
  endfunction

  // Advances the decoder state by one character and queues any bytes it completes.
  task automatic decode_char(input text_row_t row);
    logic [6:0] sx;
    logic [7:0] b [3];
    sx = sextet_of(row.ch);
    if (!sx[6]) begin
      held_count = 2'd0;
    end else if (held_count < 2'd3) begin
      held_sextets[held_count] = sx[5:0];
      held_count = row.eot ? 2'd0 : held_count + 2'd1;
    end else begin
      b[0] = {held_sextets[0], held_sextets[1][5:4]};
      b[1] = {held_sextets[1][3:0], held_sextets[2][5:2]};
      b[2] = {held_sextets[2][1:0], sx[5:0]};
      if (row.typed) begin
        b[0] = row.b0;
        b[1] = row.b1;
        b[2] = row.b2;
      end
      held_count = 2'd0;
      groups_decoded++;
      for (int i = 0; i < 3; i++) pending_bytes.push_back('{b[i], i == 2});
    end
  endtask

  // Offers one character after a random pause and records it once accepted.
  task automatic send_char(input text_row_t row);
    while (!no_idle && $urandom_range(99) < 32) begin
      char_valid <= 1'b0;
      @(posedge clk);
    end
    char_valid  <= 1'b1;
    text_char   <= row.ch;
    end_of_text <= row.eot;
    do @(posedge clk); while (!char_ready);
    decode_char(row);
    chars_sent++;
  endtask

  // Byte channel back-pressure.
  always @(posedge clk) begin
    byte_ready <= no_idle || ($urandom_range(99) >= 32);
  end

  // Each byte transaction is compared with the oldest expected byte.
  always @(posedge clk) begin
    out_byte_t exp_b;
    if (!rst && byte_valid && byte_ready) begin
      if (pending_bytes.size() == 0) begin
        $error("unexpected byte: data_byte %02h, group_last %0b", data_byte, group_last);
        errors++;
      end else begin
        exp_b = pending_bytes.pop_front();
        bytes_checked++;
        if (data_byte !== exp_b.data) begin
          $error("data_byte: expected %02h, actual %02h", exp_b.data, data_byte);
          errors++;
        end
        if (group_last !== exp_b.last) begin
          $error("group_last: expected %0b, actual %0b", exp_b.last, group_last);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel.
  always @(posedge clk) begin
    if (rst || (char_valid && char_ready) || (byte_valid && byte_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("Run stopped: no transaction for %0d cycles.", STALL_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  // Stimulus: reset, directed table, then random text.
  initial begin
    text_row_t  row;
    int         random_sent;
    held_sextets = '{default: 6'd0};
    held_count = 2'd0;
    random_sent = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (text_rows[i]) send_char(text_rows[i]);

    while (random_sent < RANDOM_CHARS) begin
      // A long stretch with no idling on either side.
      no_idle = (random_sent >= 80 && random_sent < 150);
      // Hold the sender until every queued byte has been taken.
      if (random_sent == 200 && pending_bytes.size() != 0) begin
        char_valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge clk);
      end
      row = '0;
      if ($urandom_range(99) < 86) begin
        row.ch = alphabet[$urandom_range(alphabet.len() - 1)];
      end else begin
        row.ch = 8'($urandom_range(255));
      end
      row.eot = ($urandom_range(99) < 6);
      send_char(row);
      random_sent++;
    end
    no_idle = 1'b0;
    char_valid <= 1'b0;

    // Drain the byte channel, then allow the pipeline to settle.
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_bytes.size() != 0) begin
      $error("%0d expected bytes never arrived", pending_bytes.size());
      errors++;
    end

    $display("Sent %0d characters (directed table and random text), decoding %0d groups.",
             chars_sent, groups_decoded);
    $display("Compared %0d bytes, %0d mismatches.", bytes_checked, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> base64_decoder_resync_top.f
+incdir+rtl
rtl/b64d_pkg.sv
rtl/base64_decoder_resync_top.sv
test/tb_top.sv
